// File: rtl/core/sds_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Snare drum synth package
// Word types, register indexes, sequencer codes and the sine table function
// shared by the snare drum voice modules.
// ----------------------------------------------------------------------------
package sds_pkg;

  // Field widths
  localparam int SAMPLE_W  = 24;
  localparam int VEL_W     = 16;
  localparam int PCT_W     = 7;
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 3;
  localparam int PHASE_W   = 24;
  localparam int LFSR_W    = 32;

  // Shared shift-add multiplier
  localparam int MUL_A_W   = 40;
  localparam int MUL_B_W   = 32;
  localparam int MUL_CNT_W = 6;

  // Output scaling: divide by 2^21 * 15625, the shift first, then a serial divide
  localparam int MIX_SHIFT = 21;
  localparam int DIV_N_W   = 40;
  localparam int DIV_REM_W = 14;
  localparam logic [DIV_REM_W-1:0] DIV_CONST = 14'd15625;

  localparam logic [LFSR_W-1:0] LFSR_TAPS = 32'h8020_0003;
  localparam logic [LFSR_W-1:0] LFSR_SEED = 32'h0000_ACE1;

  // Register reset values
  localparam logic [22:0]      RST_BASE_STEP  = 23'd62915;
  localparam logic [23:0]      RST_AMP_MULT   = 24'd16775468;
  localparam logic [23:0]      RST_NOISE_MULT = 24'd16774304;
  localparam logic [23:0]      RST_PITCH_MULT = 24'd16742300;
  localparam logic [PCT_W-1:0] RST_TONE       = 7'd50;
  localparam logic [PCT_W-1:0] RST_SNAP       = 7'd70;
  localparam logic [PCT_W-1:0] RST_VOLUME     = 7'd100;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE_STEP  = 3'd0,
    CFG_AMP_MULT   = 3'd1,
    CFG_NOISE_MULT = 3'd2,
    CFG_PITCH_MULT = 3'd3,
    CFG_TONE       = 3'd4,
    CFG_SNAP       = 3'd5,
    CFG_VOLUME     = 3'd6
  } cfg_idx_e;

  typedef enum logic {
    OPER_TICK    = 1'b0,
    OPER_TRIGGER = 1'b1
  } oper_e;

  // Multiply steps of one tick, in the order they run
  typedef enum logic [3:0] {
    OP_STEP  = 4'd0,
    OP_TONE  = 4'd1,
    OP_NOISE = 4'd2,
    OP_AMP   = 4'd3,
    OP_NENV  = 4'd4,
    OP_PITCH = 4'd5,
    OP_TMIX  = 4'd6,
    OP_NMIX  = 4'd7,
    OP_TTERM = 4'd8,
    OP_NTERM = 4'd9,
    OP_VV    = 4'd10,
    OP_MAG   = 4'd11
  } op_e;

  typedef enum logic [2:0] {
    S_IDLE = 3'd0,
    S_ROM  = 3'd1,
    S_LOAD = 3'd2,
    S_MUL  = 3'd3,
    S_DIV  = 3'd4,
    S_DONE = 3'd5
  } state_e;

  typedef struct packed {
    logic              operation;
    logic [VEL_W-1:0]  velocity;
  } in_word_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       active;
  } out_word_t;

  // Sine table entry idx of a 2^lg entry table, Q1.23, from a Horner series
  // on the first quadrant. Evaluated at elaboration only.
  function automatic logic [SAMPLE_W-1:0] sine_entry(int unsigned idx, int unsigned lg);
    logic [63:0] u;
    logic [63:0] r;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] one;
    logic [1:0]  quad;
    one  = 64'd1 << 30;
    u    = (64'(idx) << 24) >> lg;
    quad = u[23:22];
    r    = {42'd0, u[21:0]};
    if (quad[0]) begin
      r = (64'd1 << 22) - r;
    end
    x  = (r * 64'd1686629713) >> 22;
    x2 = (x * x) >> 30;
    t  = one;
    t  = one - ((x2 * t) >> 30) / 64'd110;
    t  = one - ((x2 * t) >> 30) / 64'd72;
    t  = one - ((x2 * t) >> 30) / 64'd42;
    t  = one - ((x2 * t) >> 30) / 64'd20;
    t  = one - ((x2 * t) >> 30) / 64'd6;
    s  = (((x * t) >> 30) + 64'd64) >> 7;
    if (s > 64'd8388607) begin
      s = 64'd8388607;
    end
    return quad[1] ? (24'd0 - s[23:0]) : s[23:0];
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/snare_drum_voice_synth.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Snare drum voice synth
// One mono snare voice: a pitch-swept sine tone plus LFSR noise, each under
// a decaying envelope, mixed and saturated to a 24-bit sample.
//
// Input words carry an operation (tick or trigger) and a velocity; every
// input word gives exactly one output word (sample, active). Both channels
// use valid/ready. Registers are written through a plain write port; the user
// must write them only while the voice is idle, as the block does not enforce it.
// A trigger, or a tick while the voice is silent, goes straight to the done state.
// A sounding tick runs twelve multiplies on one shared shift-add multiplier
// (one multiplier bit per cycle) and then a serial divide.
// One word is in work at a time. A finished word waits in the output
// register while the next input word is taken; when the receiver stalls,
// the block holds its next result until the output register frees.
// Reset loads the register defaults, silences the voice and seeds the LFSR.
// ----------------------------------------------------------------------------
module snare_drum_voice_synth #(
  parameter int SINE_TABLE_DEPTH = 1024,
  parameter int ENV_FRAC_BITS    = 24
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                in_valid_i,
  output logic                               in_ready_o,
  input  wire  sds_pkg::in_word_t            in_i,
  output logic                               out_valid_o,
  input  wire                                out_ready_i,
  output sds_pkg::out_word_t                 out_o,
  input  wire                                cfg_we_i,
  input  wire  [sds_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire  [sds_pkg::CFG_W-1:0]          cfg_wdata_i
);
  import sds_pkg::*;

  localparam int ENV_W = ENV_FRAC_BITS + 1;
  localparam int IDX_W = $clog2(SINE_TABLE_DEPTH);
  localparam int P_W   = MUL_A_W + MUL_B_W;
  localparam logic [ENV_W-1:0] ENV_ONE  = {1'b1, {ENV_FRAC_BITS{1'b0}}};
  localparam logic [ENV_W-1:0] ENV_STOP =
    ENV_W'(((64'd1 << ENV_FRAC_BITS) + 64'd5000) / 64'd10000);

  // Registers
  logic [22:0]      base_step_q;
  logic [23:0]      amp_mult_q;
  logic [23:0]      nenv_mult_q;
  logic [23:0]      pitch_mult_q;
  logic [PCT_W-1:0] tone_lvl_q;
  logic [PCT_W-1:0] snap_lvl_q;
  logic [PCT_W-1:0] vol_lvl_q;

  // Voice state
  logic               voice_q;
  logic [VEL_W-1:0]   vel_q;
  logic [PHASE_W-1:0] phase_q;
  logic [ENV_W-1:0]   amp_q;
  logic [ENV_W-1:0]   nenv_q;
  logic [ENV_W-1:0]   pitch_q;
  logic [LFSR_W-1:0]  lfsr_q;

  // Per-tick working values
  logic [SAMPLE_W-1:0] sine_q;
  logic [23:0]         tone_mag_q;
  logic [23:0]         noise_mag_q;
  logic                noise_neg_q;
  logic [13:0]         tmix_q;
  logic [13:0]         nmix_q;
  logic [39:0]         t_term_q;
  logic [39:0]         mix_mag_q;
  logic                mix_neg_q;
  logic [22:0]         vv_q;
  out_word_t           res_q;
  out_word_t           out_q;
  logic                out_valid_q;

  state_e state_q, state_d;
  op_e    op_q, op_d;

  logic                 accept;
  logic                 done_go;
  logic                 mul_start;
  logic                 mul_busy;
  logic                 mul_done;
  logic [P_W-1:0]       mul_prod;
  logic [MUL_A_W-1:0]   mul_a;
  logic [MUL_B_W-1:0]   mul_b;
  logic [MUL_CNT_W-1:0] mul_n;
  logic                 div_start;
  logic                 div_done;
  logic [DIV_N_W-1:0]   div_quot;
  logic [SAMPLE_W-1:0]  rom_data;
  logic [PCT_W-1:0]     tone_pct;
  logic [PCT_W-1:0]     snap_pct;
  logic [PCT_W-1:0]     vol_pct;
  logic [LFSR_W-1:0]    lfsr_nxt;
  logic [23:0]          sine_mag;
  logic [39:0]          n_term;
  logic [39:0]          mix_sum;
  logic [SAMPLE_W-1:0]  sat_sample;
  logic                 voice_nxt;

  // Percent settings saturate at 100.
  assign tone_pct = (tone_lvl_q > 7'd100) ? 7'd100 : tone_lvl_q;
  assign snap_pct = (snap_lvl_q > 7'd100) ? 7'd100 : snap_lvl_q;
  assign vol_pct  = (vol_lvl_q  > 7'd100) ? 7'd100 : vol_lvl_q;

  // Galois LFSR, one step per sounding tick.
  assign lfsr_nxt = lfsr_q[0] ? ({1'b0, lfsr_q[LFSR_W-1:1]} ^ LFSR_TAPS)
                              : {1'b0, lfsr_q[LFSR_W-1:1]};

  assign sine_mag = sine_q[SAMPLE_W-1] ? (24'd0 - sine_q) : sine_q;

  // Signed sum of tone and noise terms.
  assign n_term  = noise_neg_q ? (40'd0 - mul_prod[39:0]) : mul_prod[39:0];
  assign mix_sum = t_term_q + n_term;

  // Saturate the scaled magnitude to the sample range.
  always_comb begin
    if (mix_neg_q) begin
      sat_sample = (div_quot > 40'd8388608) ? 24'h80_0000 : 24'(40'd0 - div_quot);
    end else begin
      sat_sample = (div_quot > 40'd8388607) ? 24'h7F_FFFF : div_quot[23:0];
    end
  end

  assign voice_nxt = !((amp_q < ENV_STOP) && (nenv_q < ENV_STOP));

  // Multiplier operands for each step.
  always_comb begin
    unique case (op_q)
      OP_STEP: begin
        mul_a = MUL_A_W'(base_step_q);
        mul_b = MUL_B_W'(pitch_q);
        mul_n = MUL_CNT_W'(ENV_W);
      end
      OP_TONE: begin
        mul_a = MUL_A_W'(sine_mag);
        mul_b = MUL_B_W'(amp_q);
        mul_n = MUL_CNT_W'(ENV_W);
      end
      OP_NOISE: begin
        mul_a = MUL_A_W'(noise_mag_q);
        mul_b = MUL_B_W'(nenv_q);
        mul_n = MUL_CNT_W'(ENV_W);
      end
      OP_AMP: begin
        mul_a = MUL_A_W'(amp_q);
        mul_b = MUL_B_W'(amp_mult_q);
        mul_n = MUL_CNT_W'(24);
      end
      OP_NENV: begin
        mul_a = MUL_A_W'(nenv_q);
        mul_b = MUL_B_W'(nenv_mult_q);
        mul_n = MUL_CNT_W'(24);
      end
      OP_PITCH: begin
        mul_a = MUL_A_W'(pitch_q);
        mul_b = MUL_B_W'(pitch_mult_q);
        mul_n = MUL_CNT_W'(24);
      end
      OP_TMIX: begin
        mul_a = MUL_A_W'(tone_pct);
        mul_b = MUL_B_W'(7'd100);
        mul_n = MUL_CNT_W'(7);
      end
      OP_NMIX: begin
        mul_a = MUL_A_W'(snap_pct);
        mul_b = MUL_B_W'(8'd130 - {1'b0, tone_pct});
        mul_n = MUL_CNT_W'(8);
      end
      OP_TTERM: begin
        mul_a = MUL_A_W'(tone_mag_q);
        mul_b = MUL_B_W'(tmix_q);
        mul_n = MUL_CNT_W'(14);
      end
      OP_NTERM: begin
        mul_a = MUL_A_W'(noise_mag_q);
        mul_b = MUL_B_W'(nmix_q);
        mul_n = MUL_CNT_W'(14);
      end
      OP_VV: begin
        mul_a = MUL_A_W'(vol_pct);
        mul_b = MUL_B_W'(vel_q);
        mul_n = MUL_CNT_W'(16);
      end
      OP_MAG: begin
        mul_a = mix_mag_q;
        mul_b = MUL_B_W'(vv_q);
        mul_n = MUL_CNT_W'(23);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
        mul_n = MUL_CNT_W'(1);
      end
    endcase
  end

  // Sequencer: next state and strobes.
  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    in_ready_o = (state_q == S_IDLE);
    accept     = in_valid_i && in_ready_o;
    mul_start  = (state_q == S_LOAD);
    div_start  = 1'b0;
    done_go    = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d = OP_STEP;
          if (in_i.operation == OPER_TRIGGER || !voice_q) begin
            state_d = S_DONE;
          end else begin
            state_d = S_ROM;
          end
        end
      end
      S_ROM:  state_d = S_LOAD;
      S_LOAD: state_d = S_MUL;
      S_MUL: begin
        if (mul_done) begin
          if (op_q == OP_MAG) begin
            div_start = 1'b1;
            state_d   = S_DIV;
          end else begin
            op_d    = op_e'(op_q + 4'd1);
            state_d = S_LOAD;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          done_go = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q    <= OP_STEP;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

  // Register writes, voice state and per-step captures.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_step_q  <= RST_BASE_STEP;
      amp_mult_q   <= RST_AMP_MULT;
      nenv_mult_q  <= RST_NOISE_MULT;
      pitch_mult_q <= RST_PITCH_MULT;
      tone_lvl_q   <= RST_TONE;
      snap_lvl_q   <= RST_SNAP;
      vol_lvl_q    <= RST_VOLUME;
      voice_q      <= 1'b0;
      vel_q        <= '0;
      phase_q      <= '0;
      amp_q        <= '0;
      nenv_q       <= '0;
      pitch_q      <= '0;
      lfsr_q       <= LFSR_SEED;
      sine_q       <= '0;
      tone_mag_q   <= '0;
      noise_mag_q  <= '0;
      noise_neg_q  <= 1'b0;
      tmix_q       <= '0;
      nmix_q       <= '0;
      t_term_q     <= '0;
      mix_mag_q    <= '0;
      mix_neg_q    <= 1'b0;
      vv_q         <= '0;
      res_q        <= '0;
      out_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_BASE_STEP:  base_step_q  <= cfg_wdata_i[22:0];
          CFG_AMP_MULT:   amp_mult_q   <= cfg_wdata_i;
          CFG_NOISE_MULT: nenv_mult_q  <= cfg_wdata_i;
          CFG_PITCH_MULT: pitch_mult_q <= cfg_wdata_i;
          CFG_TONE:       tone_lvl_q   <= cfg_wdata_i[PCT_W-1:0];
          CFG_SNAP:       snap_lvl_q   <= cfg_wdata_i[PCT_W-1:0];
          CFG_VOLUME:     vol_lvl_q    <= cfg_wdata_i[PCT_W-1:0];
          default: ;
        endcase
      end

      // Accepted word: trigger restarts the voice, a sounding tick steps noise.
      if (accept) begin
        if (in_i.operation == OPER_TRIGGER) begin
          vel_q   <= in_i.velocity;
          voice_q <= 1'b1;
          phase_q <= '0;
          amp_q   <= ENV_ONE;
          nenv_q  <= ENV_ONE;
          pitch_q <= ENV_ONE;
          res_q   <= '{sample: '0, active: 1'b1};
        end else if (!voice_q) begin
          res_q <= '{sample: '0, active: 1'b0};
        end else begin
          lfsr_q      <= lfsr_nxt;
          noise_neg_q <= lfsr_nxt[23];
          noise_mag_q <= lfsr_nxt[23] ? (24'd0 - lfsr_nxt[23:0]) : lfsr_nxt[23:0];
        end
      end

      if (state_q == S_ROM) begin
        sine_q <= rom_data;
      end

      // Capture each multiply result.
      if (state_q == S_MUL && mul_done) begin
        unique case (op_q)
          OP_STEP:  phase_q <= phase_q + PHASE_W'(base_step_q)
                               + mul_prod[ENV_FRAC_BITS+1 +: PHASE_W];
          OP_TONE:  tone_mag_q  <= mul_prod[ENV_FRAC_BITS +: 24];
          OP_NOISE: noise_mag_q <= mul_prod[ENV_FRAC_BITS +: 24];
          OP_AMP:   amp_q   <= mul_prod[24 +: ENV_W];
          OP_NENV:  nenv_q  <= mul_prod[24 +: ENV_W];
          OP_PITCH: pitch_q <= mul_prod[24 +: ENV_W];
          OP_TMIX:  tmix_q  <= mul_prod[13:0];
          OP_NMIX:  nmix_q  <= mul_prod[13:0];
          OP_TTERM: t_term_q <= sine_q[SAMPLE_W-1] ? (40'd0 - mul_prod[39:0])
                                                    : mul_prod[39:0];
          OP_NTERM: begin
            mix_neg_q <= mix_sum[39];
            mix_mag_q <= mix_sum[39] ? (40'd0 - mix_sum) : mix_sum;
          end
          OP_VV:    vv_q <= mul_prod[22:0];
          OP_MAG:   ;
          default:  ;
        endcase
      end

      // Scaled sample ready: saturate and decide whether the voice stops.
      if (div_done) begin
        voice_q <= voice_nxt;
        res_q   <= '{sample: sat_sample, active: voice_nxt};
      end

      // Output register.
      if (done_go) begin
        out_q       <= res_q;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  sds_sine_rom #(
    .DEPTH (SINE_TABLE_DEPTH)
  ) u_rom (
    .clk_i  (clk_i),
    .addr_i (phase_q[PHASE_W-1 -: IDX_W]),
    .data_o (rom_data)
  );

  sds_ser_mul #(
    .A_W   (MUL_A_W),
    .B_W   (MUL_B_W),
    .CNT_W (MUL_CNT_W)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .nbits_i (mul_n),
    .busy_o  (mul_busy),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  sds_ser_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (mul_prod[MIX_SHIFT +: DIV_N_W]),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // A silent voice has both envelopes under the stop level.
  a_silent_env: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !voice_q |-> (amp_q < ENV_STOP && nenv_q < ENV_STOP))
    else $error("voice off with an envelope above the stop level");

  // The multiplier is never busy while a new word can be taken.
  a_idle_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !mul_busy)
    else $error("multiplier busy in idle");

  // The divider finishes only while the sequencer waits for it.
  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIV))
    else $error("divider done outside its wait state");

  // A new output word is loaded only from the done state.
  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("output word loaded outside the done state");

endmodule
`default_nettype wire

// File: rtl/core/sds_sine_rom.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Sine table ROM
// Constant table of one full sine turn in Q1.23 with a registered read port.
// ----------------------------------------------------------------------------
module sds_sine_rom #(
  parameter int DEPTH = 1024
) (
  input  wire                                  clk_i,
  input  wire  [$clog2(DEPTH)-1:0]             addr_i,
  output logic [sds_pkg::SAMPLE_W-1:0]         data_o
);
  import sds_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);

  logic [SAMPLE_W-1:0] rom_w [DEPTH];
  logic [SAMPLE_W-1:0] data_q;

  // Table contents are fixed at elaboration.
  for (genvar i = 0; i < DEPTH; i++) begin : g_entry
    assign rom_w[i] = sine_entry(i, IDX_W);
  end

  // Registered read.
  always_ff @(posedge clk_i) begin
    data_q <= rom_w[addr_i];
  end

  assign data_o = data_q;

endmodule
`default_nettype wire

// File: rtl/core/sds_ser_mul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Serial multiplier
// Shift-add multiplier taking one multiplier bit per cycle; runs for the
// number of multiplier bits given at start and pulses done with the product.
// ----------------------------------------------------------------------------
module sds_ser_mul #(
  parameter int A_W   = 40,
  parameter int B_W   = 32,
  parameter int CNT_W = 6
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   start_i,
  input  wire  [A_W-1:0]        a_i,
  input  wire  [B_W-1:0]        b_i,
  input  wire  [CNT_W-1:0]      nbits_i,
  output logic                  busy_o,
  output logic                  done_o,
  output logic [A_W+B_W-1:0]    prod_o
);
  localparam int P_W = A_W + B_W;

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [P_W-1:0]   a_q;
  logic [B_W-1:0]   b_q;
  logic [P_W-1:0]   acc_q;

  // Control: bit counter and done pulse.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= nbits_i;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: add the shifted multiplicand when the low multiplier bit is set.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= P_W'(a_i);
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_q) begin
      if (b_q[0]) begin
        acc_q <= acc_q + a_q;
      end
      a_q <= {a_q[P_W-2:0], 1'b0};
      b_q <= {1'b0, b_q[B_W-1:1]};
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule
`default_nettype wire

// File: rtl/core/sds_ser_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Serial constant divider
// Restoring divider by the constant DIV_CONST, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sds_ser_div (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           start_i,
  input  wire  [sds_pkg::DIV_N_W-1:0]   num_i,
  output logic                          done_o,
  output logic [sds_pkg::DIV_N_W-1:0]   quot_o
);
  import sds_pkg::*;

  localparam int CNT_W = $clog2(DIV_N_W + 1);

  logic                 busy_q;
  logic                 done_q;
  logic [CNT_W-1:0]     cnt_q;
  logic [DIV_N_W-1:0]   num_q;
  logic [DIV_REM_W-1:0] rem_q;
  logic [DIV_REM_W:0]   trial;
  logic                 fits;

  // Trial subtract of the divisor from the shifted remainder.
  assign trial = {rem_q, num_q[DIV_N_W-1]};
  assign fits  = trial >= {1'b0, DIV_CONST};

  // Control: bit counter and done pulse.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DIV_N_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Dividend shifts out at the top while quotient bits shift in at the bottom.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= fits ? DIV_REM_W'(trial - {1'b0, DIV_CONST}) : trial[DIV_REM_W-1:0];
      num_q <= {num_q[DIV_N_W-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = num_q;

endmodule
`default_nettype wire

// File: tb/snare_drum_voice_synth_tb.sv
// ----------------------------------------------------------------------------
// Snare drum voice synth testbench
// Drives trigger and tick words with random gaps, stalls the output side at
// random, and checks every output word against a cycle-free model of the
// voice kept in the bench. Register settings change between phases, with
// the voice idle.
// ----------------------------------------------------------------------------
module snare_drum_voice_synth_tb;
  import sds_pkg::*;

  localparam int TABLE_DEPTH = 1024;
  localparam int ENV_BITS = 24;
  localparam longint unsigned ENV_UNIT = 64'd1 << ENV_BITS;
  localparam longint unsigned SILENCE_LEVEL = (ENV_UNIT + 64'd5000) / 64'd10000;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;
  localparam int SETTLE_CYCLES = 400;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_word_t in_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_word_t out_o;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0] cfg_wdata_i = '0;

  snare_drum_voice_synth uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_i(in_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_o(out_o),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Words waiting to be sent and output words still to come.
  in_word_t pending_words[$];
  out_word_t expected_words[$];
  int error_count = 0;

  // Register copies.
  logic [22:0] base_step;
  logic [23:0] amp_mult, noise_mult, pitch_mult;
  logic [6:0] tone_pct, snap_pct, volume_pct;

  // Voice state copies.
  logic voice_on;
  logic [15:0] held_vel;
  logic [23:0] osc_phase;
  longint unsigned amp_env, noise_env, pitch_env;
  logic [31:0] noise_lfsr;

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // Sine table entry for a phase, Q1.23, from a quarter-wave series.
  function automatic longint sine_at(logic [23:0] phase);
    longint unsigned idx, u, r, x, x2, t, s;
    longint unsigned divs[5];
    logic [1:0] quad;
    divs = '{110, 72, 42, 20, 6};
    idx = (longint'(phase) * TABLE_DEPTH) >> 24;
    u = (idx << 24) / TABLE_DEPTH;
    quad = u[23:22];
    r = u & 64'h3F_FFFF;
    if (quad[0]) begin
      r = (64'd1 << 22) - r;
    end
    x = (r * 64'd1686629713) >> 22;
    x2 = (x * x) >> 30;
    t = 64'd1 << 30;
    for (int k = 0; k < 5; k++) begin
      t = (64'd1 << 30) - ((x2 * t) >> 30) / divs[k];
    end
    s = (((x * t) >> 30) + 64'd64) >> 7;
    if (s > 64'd8388607) begin
      s = 64'd8388607;
    end
    return quad[1] ? -longint'(s) : longint'(s);
  endfunction

  // Signed value times an envelope, shifted down, truncated toward zero.
  function automatic longint env_scale(longint a, longint unsigned env);
    longint unsigned mag;
    mag = (a < 0) ? longint'(-a) : a;
    mag = (mag * env) >> ENV_BITS;
    return (a < 0) ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic longint unsigned clamp_pct(logic [6:0] v);
    return (v > 7'd100) ? 64'd100 : longint'(v);
  endfunction

  // Advances the voice by one word and returns the output word it gives.
  function automatic out_word_t voice_step(in_word_t w);
    out_word_t r;
    longint unsigned tone, snap, vol, step, mag;
    longint tone_term, noise_term, noise_val, mix, smp;
    smp = 0;
    if (w.operation == OPER_TRIGGER) begin
      held_vel = w.velocity;
      voice_on = 1'b1;
      osc_phase = '0;
      amp_env = ENV_UNIT;
      noise_env = ENV_UNIT;
      pitch_env = ENV_UNIT;
    end else if (voice_on) begin
      tone = clamp_pct(tone_pct);
      snap = clamp_pct(snap_pct);
      vol = clamp_pct(volume_pct);
      step = longint'(base_step) + ((longint'(base_step) * pitch_env) >> (ENV_BITS + 1));
      tone_term = env_scale(sine_at(osc_phase), amp_env) * longint'(tone * 100);
      osc_phase = 24'(longint'(osc_phase) + step);
      if (noise_lfsr[0]) begin
        noise_lfsr = (noise_lfsr >> 1) ^ LFSR_TAPS;
      end else begin
        noise_lfsr = noise_lfsr >> 1;
      end
      noise_val = longint'($signed(noise_lfsr[23:0]));
      noise_term = env_scale(noise_val, noise_env) * longint'(snap * (130 - tone));
      mix = tone_term + noise_term;
      mag = (mix < 0) ? longint'(-mix) : mix;
      mag = (mag * vol * held_vel) / 64'd32768000000;
      if (mix < 0) begin
        smp = (mag > 64'd8388608) ? -64'sd8388608 : -longint'(mag);
      end else begin
        smp = (mag > 64'd8388607) ? 64'sd8388607 : longint'(mag);
      end
      amp_env = (amp_env * amp_mult) >> 24;
      noise_env = (noise_env * noise_mult) >> 24;
      pitch_env = (pitch_env * pitch_mult) >> 24;
      if (amp_env < SILENCE_LEVEL && noise_env < SILENCE_LEVEL) begin
        voice_on = 1'b0;
      end
    end
    r.sample = smp[23:0];
    r.active = voice_on;
    return r;
  endfunction

  // Sender: holds a word until taken, then waits a drawn gap.
  int send_gap = 0;
  bit send_burst = 1'b0;
  always @(posedge clk_i or negedge rst_ni) begin
    int n;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!(in_valid_i && !in_ready_o)) begin
      if (in_valid_i) begin
        if ($urandom_range(0, 19) == 0) send_burst = !send_burst;
        n = send_burst ? 0 : $urandom_range(0, 15);
      end else begin
        n = send_gap;
      end
      if (n == 0 && pending_words.size() > 0) begin
        in_i <= pending_words.pop_front();
        in_valid_i <= 1'b1;
        send_gap <= 0;
      end else begin
        in_valid_i <= 1'b0;
        send_gap <= (n > 0) ? n - 1 : 0;
      end
    end
  end

  // Receiver: stalls a drawn number of cycles after each word.
  int recv_wait = 0;
  bit recv_burst = 1'b0;
  always @(posedge clk_i or negedge rst_ni) begin
    int n;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (out_valid_o && out_ready_i) begin
      if ($urandom_range(0, 19) == 0) recv_burst = !recv_burst;
      n = recv_burst ? 0 : $urandom_range(0, 15);
      recv_wait <= n;
      out_ready_i <= (n == 0);
    end else if (recv_wait > 0) begin
      recv_wait <= recv_wait - 1;
      out_ready_i <= (recv_wait == 1);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Monitor: predicts on each accepted input word, checks each output word.
  always @(posedge clk_i) begin
    out_word_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        expected_words.push_back(voice_step(in_i));
      end
      if (out_valid_o && out_ready_i) begin
        if (expected_words.size() == 0) begin
          report("unexpected word", out_o.sample, 0);
        end else begin
          want = expected_words.pop_front();
          if (out_o.sample !== want.sample) report("sample", out_o.sample, want.sample);
          if (out_o.active !== want.active) report("active", out_o.active, want.active);
        end
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= value;
    case (idx)
      CFG_BASE_STEP:  base_step = value[22:0];
      CFG_AMP_MULT:   amp_mult = value;
      CFG_NOISE_MULT: noise_mult = value;
      CFG_PITCH_MULT: pitch_mult = value;
      CFG_TONE:       tone_pct = value[6:0];
      CFG_SNAP:       snap_pct = value[6:0];
      CFG_VOLUME:     volume_pct = value[6:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_voice(logic [23:0] step, logic [23:0] am, logic [23:0] nm,
                           logic [23:0] pm, logic [6:0] tn, logic [6:0] sn,
                           logic [6:0] vl);
    write_reg(CFG_BASE_STEP, step);
    write_reg(CFG_AMP_MULT, am);
    write_reg(CFG_NOISE_MULT, nm);
    write_reg(CFG_PITCH_MULT, pm);
    write_reg(CFG_TONE, CFG_W'(tn));
    write_reg(CFG_SNAP, CFG_W'(sn));
    write_reg(CFG_VOLUME, CFG_W'(vl));
  endtask

  task automatic queue_word(oper_e op, logic [15:0] vel);
    in_word_t w;
    w.operation = op;
    w.velocity = vel;
    pending_words.push_back(w);
  endtask

  // Mostly a trigger followed by a run of ticks; some stray ticks and
  // back-to-back triggers in between.
  task automatic queue_notes(int count);
    int made, ticks, pick;
    logic [15:0] vel;
    made = 0;
    while (made < count) begin
      pick = $urandom_range(0, 9);
      vel = (pick == 0) ? 16'd0 : (pick == 1) ? 16'd32768 : (pick == 2) ? 16'hFFFF
          : 16'($urandom_range(0, 65535));
      queue_word(OPER_TRIGGER, vel);
      ticks = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 40);
      for (int k = 0; k < ticks; k++) queue_word(OPER_TICK, 16'($urandom_range(0, 65535)));
      made += ticks + 1;
    end
  endtask

  task automatic wait_idle();
    while (pending_words.size() > 0 || in_valid_i || expected_words.size() > 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [23:0] fast_decay();
    return 24'($urandom_range(10066329, 16441671));
  endfunction

  initial begin
    base_step = RST_BASE_STEP;
    amp_mult = RST_AMP_MULT;
    noise_mult = RST_NOISE_MULT;
    pitch_mult = RST_PITCH_MULT;
    tone_pct = RST_TONE;
    snap_pct = RST_SNAP;
    volume_pct = RST_VOLUME;
    voice_on = 1'b0;
    held_vel = '0;
    osc_phase = '0;
    amp_env = 0;
    noise_env = 0;
    pitch_env = 0;
    noise_lfsr = LFSR_SEED;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: silent tick, full, zero and over-range velocity, retrigger.
    queue_word(OPER_TICK, 16'hFFFF);
    queue_word(OPER_TRIGGER, 16'd32768);
    repeat (4) queue_word(OPER_TICK, 16'd0);
    queue_word(OPER_TRIGGER, 16'd0);
    repeat (2) queue_word(OPER_TICK, 16'hFFFF);
    queue_word(OPER_TRIGGER, 16'hFFFF);
    repeat (3) queue_word(OPER_TICK, 16'h5555);
    queue_word(OPER_TRIGGER, 16'd1);
    repeat (2) queue_word(OPER_TICK, 16'hAAAA);
    queue_notes(60);
    wait_idle();

    // Envelopes vanish after one tick; maximum pitch step.
    set_voice(24'h7F_FFFF, 24'd0, 24'd0, 24'd0, 7'd0, 7'd100, 7'd127);
    write_reg(CFG_UNUSED_IDX, 24'hFF_FFFF);
    queue_notes(60);
    wait_idle();

    // Envelopes decay as slowly as the multipliers allow; tone and snap above range.
    set_voice(24'd0, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 7'd127, 7'd127, 7'd100);
    queue_notes(60);
    wait_idle();

    // One envelope at the slowest decay, the other fast; mute volume.
    set_voice(24'h55_5555, 24'hFF_FFFF, fast_decay(), 24'h80_0000, 7'd100, 7'd0, 7'd0);
    queue_notes(30);
    wait_idle();

    // Random settings with fast decaying envelopes.
    for (int p = 0; p < 8; p++) begin
      set_voice(24'($urandom_range(0, 8388607)), fast_decay(), fast_decay(),
                24'($urandom_range(0, 16777215)), 7'($urandom_range(0, 127)),
                7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
      queue_notes(60);
      wait_idle();
    end

    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #30000000;
    $display("simulation failed");
    $finish;
  end

endmodule
